@@ rtl/fpsp_pkg.sv @@
// Shared types and constants for the FASTA protein stream parser.
// Used by every module of the block; no dependencies.
package fpsp_pkg;

  localparam logic [2:0] KIND_NONE    = 3'd0;
  localparam logic [2:0] KIND_RESIDUE = 3'd1;
  localparam logic [2:0] KIND_ID      = 3'd2;
  localparam logic [2:0] KIND_HEADER  = 3'd3;
  localparam logic [2:0] KIND_RECORD  = 3'd4;
  localparam logic [2:0] KIND_FILE    = 3'd5;
  localparam logic [2:0] KIND_ERROR   = 3'd6;

  localparam logic [2:0] ERR_OK       = 3'd0;
  localparam logic [2:0] ERR_NO_ID    = 3'd1;
  localparam logic [2:0] ERR_NO_HDR   = 3'd2;
  localparam logic [2:0] ERR_EMPTY    = 3'd3;
  localparam logic [2:0] ERR_SYMBOL   = 3'd4;
  localparam logic [2:0] ERR_NO_REC   = 3'd5;
  localparam logic [2:0] ERR_OVERFLOW = 3'd6;

  localparam logic [2:0] PH_LINE = 3'd0;
  localparam logic [2:0] PH_SKIP = 3'd1;
  localparam logic [2:0] PH_ID   = 3'd2;
  localparam logic [2:0] PH_REST = 3'd3;
  localparam logic [2:0] PH_TAIL = 3'd4;
  localparam logic [2:0] PH_SEQ  = 3'd5;

  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_X     = 8'h58;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;
  localparam logic [7:0] CASE_GAP = 8'h20;

  localparam int MAX_RES = 3;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  data_byte;
    logic [15:0] record_index;
    logic [23:0] record_length;
    logic [23:0] longest_length;
    logic [15:0] record_total;
    logic [31:0] residue_total;
    logic [2:0]  error_code;
  } res_t;

  typedef struct packed {
    res_t [MAX_RES-1:0] slot;
    logic [1:0]         count;
  } bundle_t;

  function automatic logic is_residue(input logic [7:0] c);
    unique case (c)
      8'h41, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47, 8'h48, 8'h49, 8'h4B, 8'h4C,
      8'h4D, 8'h4E, 8'h50, 8'h51, 8'h52, 8'h53, 8'h54, 8'h56, 8'h57, 8'h59,
      8'h58: is_residue = 1'b1;
      default: is_residue = 1'b0;
    endcase
  endfunction

endpackage

@@ rtl/fpsp_if.sv @@
// Valid/ready channel interfaces: input bytes, results and configuration.
// Depends on fpsp_pkg for nothing but is compiled after it.
interface fpsp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_file;
  modport source (output valid, in_byte, end_of_file, input ready);
  modport sink (input valid, in_byte, end_of_file, output ready);
endinterface

interface fpsp_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  data_byte;
  logic [15:0] record_index;
  logic [23:0] record_length;
  logic [23:0] longest_length;
  logic [15:0] record_total;
  logic [31:0] residue_total;
  logic [2:0]  error_code;
  logic        last_of_run;
  modport source (output valid, kind, data_byte, record_index, record_length,
                  longest_length, record_total, residue_total, error_code,
                  last_of_run, input ready);
  modport sink (input valid, kind, data_byte, record_index, record_length,
                longest_length, record_total, residue_total, error_code,
                last_of_run, output ready);
endinterface

interface fpsp_cfg_if;
  logic valid;
  logic ready;
  logic strict_mode;
  modport source (output valid, strict_mode, input ready);
  modport sink (input valid, strict_mode, output ready);
endinterface

@@ rtl/fpsp_front.sv @@
// Front end: parse state, counters and classification of each byte into
// a bundle of up to three results. Depends on fpsp_pkg.
module fpsp_front import fpsp_pkg::*; #(
  parameter int LENGTH_BITS = 24,
  parameter int COUNT_BITS  = 16,
  parameter int TOTAL_BITS  = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic [7:0] in_byte,
  input  logic       end_of_file,
  input  logic       cfg_we,
  input  logic       cfg_strict,
  output bundle_t    bundle
);

  logic                   strict;
  logic [2:0]             phase, phase_next;
  logic                   rec_open, rec_open_next;
  logic [LENGTH_BITS-1:0] cur_len, cur_len_next;
  logic [LENGTH_BITS-1:0] longest, longest_next;
  logic [COUNT_BITS-1:0]  rec_cnt, rec_cnt_next;
  logic [TOTAL_BITS-1:0]  res_tot, res_tot_next;
  logic                   err, err_next;
  logic [2:0]             err_kept, err_kept_next;

  function automatic res_t mk(input logic [2:0] k, input logic [7:0] d,
                              input logic [2:0] code,
                              input logic [COUNT_BITS-1:0] cnt,
                              input logic [LENGTH_BITS-1:0] len,
                              input logic [LENGTH_BITS-1:0] lng,
                              input logic [TOTAL_BITS-1:0] tot);
    res_t r;
    r.kind           = k;
    r.data_byte      = d;
    r.record_index   = (cnt != '0) ? 16'(cnt - 1'b1) : 16'd0;
    r.record_length  = 24'(len);
    r.longest_length = 24'(lng);
    r.record_total   = 16'(cnt);
    r.residue_total  = 32'(tot);
    r.error_code     = code;
    return r;
  endfunction

  always_comb begin
    logic [2:0]             ph;
    logic                   op, e, in_seq;
    logic [LENGTH_BITS-1:0] len, lng;
    logic [COUNT_BITS-1:0]  cnt;
    logic [TOTAL_BITS-1:0]  tot;
    logic [2:0]             ek, fcode;
    logic [7:0]             c;
    logic [1:0]             n;
    logic                   do_fail, closed;
    ph = phase; op = rec_open; e = err; len = cur_len; lng = longest;
    cnt = rec_cnt; tot = res_tot; ek = err_kept; c = in_byte;
    n = 2'd0; in_seq = 1'b0; do_fail = 1'b0; fcode = ERR_OK; closed = 1'b0;
    bundle = '0;

    if (!e) begin
      unique case (ph)
        PH_LINE: begin
          if (c == CH_GT) begin
            // close the open record first
            if (op) begin
              op = 1'b0;
              if (len == '0) begin
                e = 1'b1; ek = ERR_EMPTY;
                bundle.slot[n] = mk(KIND_ERROR, 8'd0, ERR_EMPTY, cnt, len, lng, tot);
                n = n + 2'd1;
              end else begin
                if (len > lng) lng = len;
                bundle.slot[n] = mk(KIND_RECORD, 8'd0, ERR_OK, cnt, len, lng, tot);
                n = n + 2'd1;
              end
            end
            if (!e) begin
              if (&cnt) begin
                do_fail = 1'b1; fcode = ERR_OVERFLOW;
              end else begin
                cnt = cnt + 1'b1; op = 1'b1; len = '0; ph = PH_SKIP;
              end
            end
          end else if (!op) begin
            do_fail = 1'b1; fcode = ERR_NO_HDR;
          end else begin
            ph = PH_SEQ; in_seq = 1'b1;
          end
        end
        PH_SKIP: begin
          if (c == CH_CR || c == CH_LF) begin
            do_fail = 1'b1; fcode = ERR_NO_ID;
          end else if (c != CH_SPACE && c != CH_TAB) begin
            bundle.slot[n] = mk(KIND_ID, c, ERR_OK, cnt, len, lng, tot);
            n = n + 2'd1;
            ph = PH_ID;
          end
        end
        PH_ID, PH_REST: begin
          if (c == CH_CR) ph = PH_TAIL;
          else if (c == CH_LF) ph = PH_LINE;
          else if (ph == PH_ID && c != CH_SPACE && c != CH_TAB) begin
            bundle.slot[n] = mk(KIND_ID, c, ERR_OK, cnt, len, lng, tot);
            n = n + 2'd1;
          end else begin
            bundle.slot[n] = mk(KIND_HEADER, c, ERR_OK, cnt, len, lng, tot);
            n = n + 2'd1;
            ph = PH_REST;
          end
        end
        PH_TAIL: begin
          if (c == CH_LF) ph = PH_LINE;
        end
        default: in_seq = 1'b1;
      endcase

      if (in_seq) begin
        if (c == CH_LF) ph = PH_LINE;
        else if (c != CH_CR && c != CH_SPACE && c != CH_TAB) begin
          if (c >= CH_LO_A && c <= CH_LO_Z) c = c - CASE_GAP;
          if (c == CH_STAR || c == CH_DASH) begin
            do_fail = strict; fcode = ERR_SYMBOL;
          end else if (!is_residue(c) && strict) begin
            do_fail = 1'b1; fcode = ERR_SYMBOL;
          end else begin
            if (!is_residue(c)) c = CH_X;
            if ((&len) || (&tot)) begin
              do_fail = 1'b1; fcode = ERR_OVERFLOW;
            end else begin
              len = len + 1'b1; tot = tot + 1'b1;
              bundle.slot[n] = mk(KIND_RESIDUE, c, ERR_OK, cnt, len, lng, tot);
              n = n + 2'd1;
            end
          end
        end
      end

      if (do_fail && !e) begin
        e = 1'b1; ek = fcode;
        bundle.slot[n] = mk(KIND_ERROR, 8'd0, fcode, cnt, len, lng, tot);
        n = n + 2'd1;
      end
    end

    if (end_of_file) begin
      if (!e) begin
        if (op && ph == PH_SKIP) begin
          e = 1'b1; ek = ERR_NO_ID;
          bundle.slot[n] = mk(KIND_ERROR, 8'd0, ERR_NO_ID, cnt, len, lng, tot);
          n = n + 2'd1;
        end else if (op) begin
          op = 1'b0; closed = 1'b1;
          if (len == '0) begin
            e = 1'b1; ek = ERR_EMPTY;
            bundle.slot[n] = mk(KIND_ERROR, 8'd0, ERR_EMPTY, cnt, len, lng, tot);
            n = n + 2'd1;
          end else begin
            if (len > lng) lng = len;
            bundle.slot[n] = mk(KIND_RECORD, 8'd0, ERR_OK, cnt, len, lng, tot);
            n = n + 2'd1;
          end
        end
      end
      if (!e && cnt == '0) begin
        e = 1'b1; ek = ERR_NO_REC;
        bundle.slot[n] = mk(KIND_ERROR, 8'd0, ERR_NO_REC, cnt, len, lng, tot);
        n = n + 2'd1;
      end
      bundle.slot[n] = mk(KIND_FILE, 8'd0, e ? ek : ERR_OK, cnt, len, lng, tot);
      n = n + 2'd1;
      // file over: parse state and counters back to reset values
      ph = PH_LINE; op = 1'b0; len = '0; lng = '0; cnt = '0; tot = '0;
      e = 1'b0; ek = ERR_OK;
    end

    bundle.count = n;
    phase_next = ph; rec_open_next = op; cur_len_next = len;
    longest_next = lng; rec_cnt_next = cnt; res_tot_next = tot;
    err_next = e; err_kept_next = closed ? ek : ek;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strict   <= 1'b0;
      phase    <= PH_LINE;
      rec_open <= 1'b0;
      cur_len  <= '0;
      longest  <= '0;
      rec_cnt  <= '0;
      res_tot  <= '0;
      err      <= 1'b0;
      err_kept <= ERR_OK;
    end else begin
      if (cfg_we) strict <= cfg_strict;
      if (take) begin
        phase    <= phase_next;
        rec_open <= rec_open_next;
        cur_len  <= cur_len_next;
        longest  <= longest_next;
        rec_cnt  <= rec_cnt_next;
        res_tot  <= res_tot_next;
        err      <= err_next;
        err_kept <= err_kept_next;
      end
    end
  end

endmodule

@@ rtl/fpsp_queue.sv @@
// Two-entry bundle queue between the front and back ends.
// Depends on fpsp_pkg.
module fpsp_queue import fpsp_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  bundle_t wdata,
  input  logic    pop,
  output bundle_t head,
  output logic    full,
  output logic    empty
);

  bundle_t    q [2];
  logic       wp, rp;
  logic [1:0] fill;

  assign head  = q[rp];
  assign full  = fill == 2'd2;
  assign empty = fill == 2'd0;

  always_ff @(posedge clk) begin
    if (push) q[wp] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= 1'b0;
      rp   <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

@@ rtl/fpsp_back.sv @@
// Back end: steps through the results of the head bundle, one beat each.
// Depends on fpsp_pkg and the result interface.
module fpsp_back import fpsp_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  bundle_t      head,
  input  logic         empty,
  output logic         pop,
  fpsp_res_if.source   res
);

  logic [1:0] ptr;
  logic       last;
  res_t       cur;

  assign cur  = head.slot[ptr];
  assign last = (ptr + 2'd1) == head.count;
  assign pop  = res.valid && res.ready && last;

  assign res.valid          = !empty;
  assign res.kind           = cur.kind;
  assign res.data_byte      = cur.data_byte;
  assign res.record_index   = cur.record_index;
  assign res.record_length  = cur.record_length;
  assign res.longest_length = cur.longest_length;
  assign res.record_total   = cur.record_total;
  assign res.residue_total  = cur.residue_total;
  assign res.error_code     = cur.error_code;
  assign res.last_of_run    = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr <= 2'd0;
    end else if (res.valid && res.ready) begin
      // advance within the bundle, wrap on its last beat
      ptr <= last ? 2'd0 : ptr + 2'd1;
    end
  end

endmodule

@@ rtl/fasta_protein_stream_parser_core.sv @@
// FASTA protein stream parser: top level tying front, queue and back.
// Depends on fpsp_pkg, the channel interfaces and the three sub-blocks.
//
// Usage: bytes of a FASTA file arrive on src, one beat per byte, with
// end_of_file set on the final byte. Each byte yields zero to three result
// beats on res (residues, id and header bytes, record done, error, file
// done); last_of_run marks the final beat caused by a byte. cfg writes the
// strict_mode bit and is always ready; write it only while idle.
// A byte's results are written into the bundle queue when it is taken.
// Throughput: one byte per cycle while the two-entry queue is not full;
// a byte with several results is given out one beat at a time by the
// single result port of the back end, so such bytes can fill the queue.
// Bytes with no result push nothing into the queue and produce no beat.
// Reset (rst, synchronous) clears parse state, counters, queue and
// strict_mode. When res stalls the queue fills and src ready drops after
// two pending bundles; nothing is lost. At end of file every count and
// the latched error return to their reset values.
module fasta_protein_stream_parser_core import fpsp_pkg::*; #(
  parameter int LENGTH_BITS = 24,
  parameter int COUNT_BITS  = 16,
  parameter int TOTAL_BITS  = 32
) (
  input  logic        clk,
  input  logic        rst,
  fpsp_byte_if.sink   src,
  fpsp_res_if.source  res,
  fpsp_cfg_if.sink    cfg
);

  bundle_t bundle, head;
  logic    take, full, empty, pop;

  assign src.ready = !full;
  assign cfg.ready = 1'b1;
  assign take      = src.valid && src.ready;

  fpsp_front #(
    .LENGTH_BITS (LENGTH_BITS),
    .COUNT_BITS  (COUNT_BITS),
    .TOTAL_BITS  (TOTAL_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .in_byte     (src.in_byte),
    .end_of_file (src.end_of_file),
    .cfg_we      (cfg.valid),
    .cfg_strict  (cfg.strict_mode),
    .bundle      (bundle)
  );

  fpsp_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (take && bundle.count != 2'd0),
    .wdata (bundle),
    .pop   (pop),
    .head  (head),
    .full  (full),
    .empty (empty)
  );

  fpsp_back u_back (
    .clk   (clk),
    .rst   (rst),
    .head  (head),
    .empty (empty),
    .pop   (pop),
    .res   (res)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(full && take && bundle.count != 2'd0 && !pop))
    else $error("queue written while full");

  a_file_last: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.kind == KIND_FILE |-> res.last_of_run)
    else $error("file done is not the last beat of its byte");

  a_code_kind: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.error_code != ERR_OK |->
      (res.kind == KIND_ERROR || res.kind == KIND_FILE))
    else $error("error code on a plain result");

endmodule

@@ tb/tb_fpsp_checker.sv @@
// Checker for the FASTA protein stream parser: watches the byte, result and
// configuration channels, predicts result beats and compares them.
// Depends on fpsp_pkg and the channel interfaces.
module tb_fpsp_checker import fpsp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  fpsp_byte_if      src,
  fpsp_res_if       res,
  fpsp_cfg_if       cfg,
  output int        fail_count,
  output int        pending
);

  typedef struct packed {
    res_t res;
    logic last;
  } beat_t;

  localparam logic [23:0] LEN_TOP = '1;
  localparam logic [15:0] CNT_TOP = '1;
  localparam logic [31:0] TOT_TOP = '1;

  beat_t       beat_q[$];
  logic        strict_q;
  logic [2:0]  phase_q;
  logic        open_q;
  logic [23:0] cur_len;
  logic [23:0] longest_q;
  logic [15:0] rec_cnt;
  logic [31:0] res_cnt;
  logic        err_q;
  logic [2:0]  err_code_q;
  int          run_n;

  assign pending = beat_q.size();

  task automatic report(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    fail_count++;
  endtask

  function automatic void clear_parse();
    phase_q = PH_LINE; open_q = 0; cur_len = 0; longest_q = 0;
    rec_cnt = 0; res_cnt = 0; err_q = 0; err_code_q = ERR_OK;
  endfunction

  function automatic void push_beat(input logic [2:0] k, input logic [7:0] b,
                                    input logic [2:0] code);
    beat_t e;
    e.res.kind = k;
    e.res.data_byte = b;
    e.res.record_index = (rec_cnt != 0) ? rec_cnt - 16'd1 : 16'd0;
    e.res.record_length = cur_len;
    e.res.longest_length = longest_q;
    e.res.record_total = rec_cnt;
    e.res.residue_total = res_cnt;
    e.res.error_code = code;
    e.last = 0;
    beat_q.push_back(e);
    run_n++;
  endfunction

  function automatic void raise(input logic [2:0] code);
    if (err_q) return;
    err_q = 1;
    err_code_q = code;
    push_beat(KIND_ERROR, 8'd0, code);
  endfunction

  function automatic void close_record();
    if (!open_q) return;
    open_q = 0;
    if (cur_len == 0) begin
      raise(ERR_EMPTY);
      return;
    end
    if (cur_len > longest_q) longest_q = cur_len;
    push_beat(KIND_RECORD, 8'd0, ERR_OK);
  endfunction

  function automatic bit amino(input logic [7:0] c);
    return c inside {"A","C","D","E","F","G","H","I","K","L","M","N","P","Q",
                     "R","S","T","V","W","Y","X"};
  endfunction

  function automatic void sequence_byte(input logic [7:0] c);
    if (c == CH_LF) begin
      phase_q = PH_LINE;
      return;
    end
    if (c == CH_CR || c == CH_SPACE || c == CH_TAB) return;
    if (c >= CH_LO_A && c <= CH_LO_Z) c = c - CASE_GAP;
    if (c == CH_STAR || c == CH_DASH) begin
      if (strict_q) raise(ERR_SYMBOL);
      return;
    end
    if (!amino(c)) begin
      if (strict_q) begin
        raise(ERR_SYMBOL);
        return;
      end
      c = CH_X;
    end
    if (cur_len == LEN_TOP || res_cnt == TOT_TOP) begin
      raise(ERR_OVERFLOW);
      return;
    end
    cur_len++;
    res_cnt++;
    push_beat(KIND_RESIDUE, c, ERR_OK);
  endfunction

  function automatic void parse(input logic [7:0] c);
    case (phase_q)
      PH_LINE: begin
        if (c == CH_GT) begin
          close_record();
          if (err_q) return;
          if (rec_cnt == CNT_TOP) begin
            raise(ERR_OVERFLOW);
            return;
          end
          rec_cnt++;
          open_q = 1;
          cur_len = 0;
          phase_q = PH_SKIP;
        end else if (!open_q) begin
          raise(ERR_NO_HDR);
        end else begin
          phase_q = PH_SEQ;
          sequence_byte(c);
        end
      end
      PH_SKIP: begin
        if (c == CH_SPACE || c == CH_TAB) return;
        if (c == CH_CR || c == CH_LF) begin
          raise(ERR_NO_ID);
          return;
        end
        push_beat(KIND_ID, c, ERR_OK);
        phase_q = PH_ID;
      end
      PH_ID: begin
        if (c == CH_CR) phase_q = PH_TAIL;
        else if (c == CH_LF) phase_q = PH_LINE;
        else if (c == CH_SPACE || c == CH_TAB) begin
          push_beat(KIND_HEADER, c, ERR_OK);
          phase_q = PH_REST;
        end else push_beat(KIND_ID, c, ERR_OK);
      end
      PH_REST: begin
        if (c == CH_CR) phase_q = PH_TAIL;
        else if (c == CH_LF) phase_q = PH_LINE;
        else push_beat(KIND_HEADER, c, ERR_OK);
      end
      PH_TAIL: if (c == CH_LF) phase_q = PH_LINE;
      default: sequence_byte(c);
    endcase
  endfunction

  function automatic void predict(input logic [7:0] c, input logic eof);
    run_n = 0;
    if (!err_q) parse(c);
    if (eof) begin
      if (!err_q) begin
        if (open_q && phase_q == PH_SKIP) raise(ERR_NO_ID);
        else close_record();
      end
      if (!err_q && rec_cnt == 0) raise(ERR_NO_REC);
      push_beat(KIND_FILE, 8'd0, err_q ? err_code_q : ERR_OK);
      clear_parse();
    end
    if (run_n > 0) beat_q[$].last = 1;
  endfunction

  initial begin
    fail_count = 0;
    strict_q = 0;
    clear_parse();
  end

  always @(posedge clk) begin
    beat_t e;
    if (rst) begin
      strict_q = 0;
      clear_parse();
      beat_q.delete();
    end else begin
      if (res.valid && res.ready) begin
        if (beat_q.size() == 0) report($sformatf("unexpected beat kind %0d", res.kind));
        else begin
          e = beat_q.pop_front();
          if (res.kind !== e.res.kind)
            report($sformatf("kind %0d, want %0d", res.kind, e.res.kind));
          if (res.data_byte !== e.res.data_byte)
            report($sformatf("data_byte %h, want %h", res.data_byte, e.res.data_byte));
          if (res.record_index !== e.res.record_index)
            report($sformatf("record_index %0d, want %0d", res.record_index,
                             e.res.record_index));
          if (res.record_length !== e.res.record_length)
            report($sformatf("record_length %0d, want %0d", res.record_length,
                             e.res.record_length));
          if (res.longest_length !== e.res.longest_length)
            report($sformatf("longest_length %0d, want %0d", res.longest_length,
                             e.res.longest_length));
          if (res.record_total !== e.res.record_total)
            report($sformatf("record_total %0d, want %0d", res.record_total,
                             e.res.record_total));
          if (res.residue_total !== e.res.residue_total)
            report($sformatf("residue_total %0d, want %0d", res.residue_total,
                             e.res.residue_total));
          if (res.error_code !== e.res.error_code)
            report($sformatf("error_code %0d, want %0d", res.error_code,
                             e.res.error_code));
          if (res.last_of_run !== e.last)
            report($sformatf("last_of_run %0d, want %0d", res.last_of_run, e.last));
        end
      end
      if (src.valid && src.ready) predict(src.in_byte, src.end_of_file);
      if (cfg.valid && cfg.ready) strict_q = cfg.strict_mode;
    end
  end

endmodule

@@ tb/tb.sv @@
// Top of the FASTA protein stream parser testbench: clock, reset, byte
// stimulus, result back-pressure, configuration writes and verdict.
// Depends on fpsp_pkg, the channel interfaces, the core and tb_fpsp_checker.
module tb import fpsp_pkg::*;;

  localparam int STALL_LIMIT = 5000;

  logic clk;
  logic rst;
  int   fail_count;
  int   pending;
  int   accepted;
  int   idle_cycles;
  bit   calm;
  bit   hold_off;
  bit   sent_all;
  bit   strict_now;

  fpsp_byte_if byte_ch ();
  fpsp_res_if  res_ch ();
  fpsp_cfg_if  cfg_ch ();

  fasta_protein_stream_parser_core i_dut (
    .clk (clk),
    .rst (rst),
    .src (byte_ch.sink),
    .res (res_ch.source),
    .cfg (cfg_ch.sink)
  );

  tb_fpsp_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .src        (byte_ch),
    .res        (res_ch),
    .cfg        (cfg_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Random sink stalls; a long hold-off on request.
  initial begin
    res_ch.ready = 0;
    forever begin
      @(negedge clk);
      if (hold_off) res_ch.ready <= 0;
      else res_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= 34);
    end
  end

  // Watchdog on acceptances.
  always @(posedge clk) begin
    if (rst || (byte_ch.valid && byte_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("fasta_protein_stream_parser_core verification failed");
      $finish;
    end
  end

  // Leave valid high on return; the next beat or drain() drops it.
  task automatic send_byte(input logic [7:0] b, input logic eof);
    while (!calm && $urandom_range(99) < 34) begin
      byte_ch.valid <= 0;
      @(negedge clk);
    end
    byte_ch.valid <= 1;
    byte_ch.in_byte <= b;
    byte_ch.end_of_file <= eof;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    accepted++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s, input bit eof);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], eof && (i == s.len() - 1));
  endtask

  task automatic drain();
    byte_ch.valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_strict(input bit v);
    drain();
    cfg_ch.valid <= 1;
    cfg_ch.strict_mode <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 0;
    strict_now = v;
  endtask

  function automatic logic [7:0] pick_residue();
    string r;
    r = "ACDEFGHIKLMNPQRSTVWYXacdefghiklmnpqrstvwy";
    return r[$urandom_range(r.len() - 1)];
  endfunction

  function automatic logic [7:0] pick_noise();
    case ($urandom_range(7))
      0: return CH_STAR;
      1: return CH_DASH;
      2: return CH_SPACE;
      3: return CH_CR;
      4: return 8'h00;
      5: return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // One file of well-formed records with random content, some noise.
  task automatic random_file(input int budget);
    int recs;
    int n;
    recs = $urandom_range(1, 3);
    for (int r = 0; r < recs && budget > 0; r++) begin
      send_byte(CH_GT, 1'b0);
      if ($urandom_range(3) == 0) send_byte(CH_TAB, 1'b0);
      n = $urandom_range(1, 4);
      for (int k = 0; k < n; k++) send_byte(8'($urandom_range(8'h21, 8'h7E)), 1'b0);
      if ($urandom_range(1)) begin
        send_byte(CH_SPACE, 1'b0);
        send_byte(8'($urandom_range(255)), 1'b0);
      end
      if ($urandom_range(1)) send_byte(CH_CR, 1'b0);
      send_byte(CH_LF, 1'b0);
      n = $urandom_range(1, 12);
      for (int k = 0; k < n; k++) begin
        if ($urandom_range(9) == 0) send_byte(pick_noise(), 1'b0);
        else if ($urandom_range(11) == 0) send_byte(CH_LF, 1'b0);
        else send_byte(pick_residue(), 1'b0);
        budget--;
      end
      send_byte(CH_LF, 1'b0);
      budget -= 8;
    end
    if ($urandom_range(5) == 0) send_byte(pick_noise(), 1'b1);
    else send_byte(pick_residue(), 1'b1);
  endtask

  initial begin
    int sent_before;
    rst = 1;
    calm = 0;
    hold_off = 0;
    sent_all = 0;
    accepted = 0;
    idle_cycles = 0;
    byte_ch.valid = 0;
    byte_ch.in_byte = 0;
    byte_ch.end_of_file = 0;
    cfg_ch.valid = 0;
    cfg_ch.strict_mode = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed: headers, extremes of the byte, every error but overflow.
    send_text(">id1 desc\r\nacXz*-\t\r\nB\n", 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_text("Q\n>a", 1'b1);
    send_text(">\n", 1'b1);
    send_text(">e\n>f\nW", 1'b1);
    send_byte(CH_LF, 1'b1);
    send_text(">h\r\n", 1'b1);
    set_strict(1'b1);
    send_text(">s\nAC*G", 1'b1);
    send_text(">s\nK?", 1'b1);
    send_text(">s\nLLM", 1'b1);
    set_strict(1'b0);

    // Long receiver hold-off while the sender keeps pushing.
    fork
      begin
        hold_off = 1;
        repeat (60) @(negedge clk);
        hold_off = 0;
      end
    join_none
    send_text(">hold\nACDEFGHIKLMNPQRS\n", 1'b1);
    drain();

    // Random files; a calm stretch in the middle, strict mode part of the way.
    sent_before = accepted;
    while (accepted - sent_before < 170) begin
      calm = (accepted - sent_before > 60) && (accepted - sent_before < 110);
      if ($urandom_range(9) == 0) begin
        set_strict(!strict_now);
      end
      if ($urandom_range(7) == 0) begin
        for (int k = $urandom_range(1, 6); k > 0; k--)
          send_byte(8'($urandom_range(255)), 1'b0);
        send_byte(8'($urandom_range(255)), 1'b1);
      end else random_file(30);
    end
    calm = 0;
    set_strict(1'b0);
    sent_all = 1;

    fork
      drain();
      begin
        repeat (20000) @(negedge clk);
      end
    join_any
    if (fail_count == 0 && pending == 0)
      $display("fasta_protein_stream_parser_core verification clean");
    else $display("fasta_protein_stream_parser_core verification failed");
    $finish;
  end

endmodule
